>>> src/bgsr_pkg.sv
// Shared types, constants, font ROM and microcode ROM for the glyph renderer.
// No dependencies; imported by every module of the block.
package bgsr_pkg;

   localparam int GLYPH_COLUMNS = 6;
   localparam int GLYPH_ROWS    = 8;
   localparam int GLYPH_COUNT   = 95;
   localparam int ADDRESS_BITS  = 16;
   localparam int FIRST_CODE    = 32;
   localparam int GLYPH_BITS    = 4 + 8 * GLYPH_COLUMNS;

   localparam int COL_W  = $clog2(GLYPH_COLUMNS + 1);
   localparam int ROW_W  = $clog2(GLYPH_ROWS);
   localparam int GIDX_W = $clog2(GLYPH_COUNT);

   // register indexes on the csr port
   localparam logic [2:0] CSR_FG_COLOR     = 3'd0;
   localparam logic [2:0] CSR_BG_COLOR     = 3'd1;
   localparam logic [2:0] CSR_ROW_STRIDE   = 3'd2;
   localparam logic [2:0] CSR_SCALE_MODE   = 3'd3;
   localparam logic [2:0] CSR_FULL_WIDTH   = 3'd4;
   localparam logic [2:0] CSR_GAP_COLUMNS  = 3'd5;
   localparam logic [2:0] CSR_CURSOR_LIMIT = 3'd6;

   localparam logic [1:0] SCALE_X1 = 2'd0;
   localparam logic [1:0] SCALE_X2 = 2'd1;

   typedef struct packed {
      logic [7:0]              fg_color;
      logic [7:0]              bg_color;
      logic [7:0]              row_stride;
      logic [1:0]              scale_mode;
      logic                    full_width;
      logic [2:0]              gap_columns;
      logic [ADDRESS_BITS-1:0] cursor_limit;
   } cfg_type;

   // microcode step addresses
   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT    = 3'd0;
   localparam step_type STEP_TEST    = 3'd1;
   localparam step_type STEP_SKIP    = 3'd2;
   localparam step_type STEP_DRAW    = 3'd3;
   localparam step_type STEP_ADVANCE = 3'd4;

   typedef enum logic [2:0] {
      COND_NO_ACCEPT = 3'd0,
      COND_DROP      = 3'd1,
      COND_NO_COLS   = 3'd2,
      COND_MORE      = 3'd3,
      COND_ALWAYS    = 3'd4
   } cond_type;

   // datapath strobes of one control word
   typedef struct packed {
      logic req_ready;
      logic load_glyph;
      logic emit;
      logic advance;
   } ctl_type;

   typedef struct packed {
      ctl_type  ctl;
      cond_type cond;
      step_type target;
   } ucode_type;

   // datapath flags tested by the jump conditions
   typedef struct packed {
      logic drop;
      logic no_cols;
      logic final_fire;
   } status_type;

   // next = cond ? target : step + 1
   function automatic ucode_type ucode_word(input step_type step);
      ucode_type w;
      w = '{ctl: '0, cond: COND_ALWAYS, target: STEP_WAIT};
      case (step)
         STEP_WAIT: begin
            w.ctl.req_ready = 1'b1;
            w.cond          = COND_NO_ACCEPT;
            w.target        = STEP_WAIT;
         end
         STEP_TEST: begin
            w.ctl.load_glyph = 1'b1;
            w.cond           = COND_DROP;
            w.target         = STEP_WAIT;
         end
         STEP_SKIP: begin
            w.cond   = COND_NO_COLS;
            w.target = STEP_ADVANCE;
         end
         STEP_DRAW: begin
            w.ctl.emit = 1'b1;
            w.cond     = COND_MORE;
            w.target   = STEP_DRAW;
         end
         STEP_ADVANCE: begin
            w.ctl.advance = 1'b1;
            w.cond        = COND_ALWAYS;
            w.target      = STEP_WAIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   // font entry: column 0 in the top byte down to column 5, then
   // right inset [3:2] and left inset [1:0]
   localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
      52'h000000000000_6, 52'h0000005e0000_b, 52'h000006000600_6, 52'h00247e247e24_1,
      52'h004854fe5424_1, 52'h004820104800_5, 52'h00344a542050_1, 52'h000000060000_b,
      52'h00003c420000_a, 52'h0000423c0000_a, 52'h000054385400_6, 52'h000010381000_6,
      52'h000080600000_a, 52'h000010100000_a, 52'h000000400000_b, 52'h006018060000_9,
      52'h00003c423c00_6, 52'h0000047e0000_6, 52'h000062524c00_6, 52'h0000424a3600_6,
      52'h00001c107e00_6, 52'h00004e4a3200_6, 52'h00003c4a3200_6, 52'h000002720e00_6,
      52'h0000344a3400_6, 52'h00004c523c00_6, 52'h000000480000_b, 52'h000080640000_a,
      52'h000010284400_6, 52'h000028282800_6, 52'h000044281000_6, 52'h0000520a0400_6,
      52'h007c8292aa3c_1, 52'h00007c127c00_6, 52'h00007e4a3400_6, 52'h00003c424200_6,
      52'h00007e423c00_6, 52'h00007e4a4200_6, 52'h00007e0a0200_6, 52'h00003c427200_6,
      52'h00007e087e00_6, 52'h0000427e4200_6, 52'h0000807e0000_a, 52'h00007e087600_6,
      52'h00007e404000_6, 52'h007e0408047e_1, 52'h007e04087e00_5, 52'h00003c423c00_6,
      52'h00007e120c00_6, 52'h00003cc2bc00_6, 52'h00007e126c00_6, 52'h0000444a3200_6,
      52'h0000027e0200_6, 52'h00003e407e00_6, 52'h00007e201e00_6, 52'h003e4030403e_1,
      52'h000066186600_6, 52'h00000e700e00_6, 52'h0000625a4600_6, 52'h00007e420000_a,
      52'h000006186000_6, 52'h0000427e0000_a, 52'h0008047e0408_1, 52'h000080808000_6,
      52'h00487c4a4200_5, 52'h000020547800_6, 52'h00007e443800_6, 52'h000038440000_a,
      52'h000038447e00_6, 52'h000038544c00_6, 52'h00007c0a0000_a, 52'h000098a47c00_6,
      52'h00007e047800_6, 52'h0000007a0000_b, 52'h0000807a0000_a, 52'h00007e186400_6,
      52'h0000007e0000_b, 52'h007c047c0478_1, 52'h00007c047800_6, 52'h000038443800_6,
      52'h0000fc447800_6, 52'h00003824fc00_6, 52'h000078040000_a, 52'h000048542400_6,
      52'h00003e440000_a, 52'h00003c407c00_6, 52'h00007c201c00_6, 52'h003c4038403c_1,
      52'h00006c106c00_6, 52'h00001ca07c00_6, 52'h000064544c00_6, 52'h000008764200_6,
      52'h0000007e0000_b, 52'h004276080000_9, 52'h000402040200_5
   };

   function automatic logic [7:0] glyph_column(input logic [GLYPH_BITS-1:0] g,
                                              input logic [COL_W-1:0]      k);
      logic [7:0] b;
      case (k)
         3'd0:    b = g[51:44];
         3'd1:    b = g[43:36];
         3'd2:    b = g[35:28];
         3'd3:    b = g[27:20];
         3'd4:    b = g[19:12];
         3'd5:    b = g[11:4];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> src/bitmap_glyph_string_renderer_top.sv
// Channel    | Dir | Signals                     | tdata/tuser contents (low bit up)
// req        | in  | req_tvalid/tready/tdata     | char_code[7:0] start_flag[8] start_offset[24:9]
// rsp        | out | rsp_tvalid/tready/tdata/tlast | pixel_address[15:0] pixel_value[23:16]
// csr        | in  | csr_we/index/wdata          | register index 0..6, data up to 16 bits
//
// Steps: a kept glyph goes through accept, font lookup, width test, one pixel
//   word per cycle while rsp_tready allows, cursor update. A dropped character
//   ends after accept and font lookup. The single pixel emit step sets the rate.
// Reset: synchronous, active high; cursor 0, registers to their defaults, no pending word.
// Stalls: rsp_tready low holds the draw step; the output register lets the last word
//   wait while the next character is accepted.
//
// Top level of the glyph renderer. Holds the csr registers and ties the
// microcode sequencer to the datapath. Depends on bgsr_pkg, bgsr_sequencer,
// bgsr_datapath.
module bitmap_glyph_string_renderer_top
   import bgsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req word: char_code[7:0], start_flag[8], start_offset[24:9], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp word: pixel_address[15:0], pixel_value[23:16]; tlast = last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // csr write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   ctl_type    ctl;
   status_type status;

   logic [ADDRESS_BITS-1:0] pixel_address;
   logic [7:0]              pixel_value;

   // csr file; the host must write it only while the block is idle, which the block does not enforce
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FG_COLOR:     cfg_in.fg_color     = csr_wdata[7:0];
            CSR_BG_COLOR:     cfg_in.bg_color     = csr_wdata[7:0];
            CSR_ROW_STRIDE:   cfg_in.row_stride   = csr_wdata[7:0];
            CSR_SCALE_MODE:   cfg_in.scale_mode   = csr_wdata[1:0];
            CSR_FULL_WIDTH:   cfg_in.full_width   = csr_wdata[0];
            CSR_GAP_COLUMNS:  cfg_in.gap_columns  = csr_wdata[2:0];
            CSR_CURSOR_LIMIT: cfg_in.cursor_limit = csr_wdata[ADDRESS_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color     <= 8'd15;
         cfg_ff.bg_color     <= 8'd0;
         cfg_ff.row_stride   <= 8'd128;
         cfg_ff.scale_mode   <= 2'd0;
         cfg_ff.full_width   <= 1'b0;
         cfg_ff.gap_columns  <= 3'd1;
         cfg_ff.cursor_limit <= 16'd8184;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // step counter and control ROM
   bgsr_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .ctl        (ctl)
   );

   // cursor, glyph walk and pixel output register
   bgsr_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .ctl               (ctl),
      .status            (status),
      .req_tvalid        (req_tvalid),
      .req_char_code     (req_tdata[7:0]),
      .req_start_flag    (req_tdata[8]),
      .req_start_offset  (req_tdata[24:9]),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_pixel_address (pixel_address),
      .rsp_pixel_value   (pixel_value),
      .rsp_last_pixel    (rsp_tlast)
   );

   assign req_tready = ctl.req_ready;
   assign rsp_tdata  = {pixel_value, pixel_address};

endmodule

>>> src/bgsr_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup, conditional jumps.
// Depends on bgsr_pkg (microcode ROM, control and status structs).
module bgsr_sequencer
   import bgsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output ctl_type    ctl
);

   step_type  step_ff, step_in;
   ucode_type word;
   logic      jump;

   assign word = ucode_word(step_ff);
   assign ctl  = word.ctl;

   always_comb begin
      case (word.cond)
         COND_NO_ACCEPT: jump = !req_tvalid;
         COND_DROP:      jump = status.drop;
         COND_NO_COLS:   jump = status.no_cols;
         COND_MORE:      jump = !status.final_fire;
         COND_ALWAYS:    jump = 1'b1;
         default:        jump = 1'b1;
      endcase
      step_in = jump ? word.target : step_type'(step_ff + 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // an accepted word is looked up in the font on the next step
   a_accept_to_test: assert property (@(posedge clock) disable iff (reset)
      (ctl.req_ready && req_tvalid) |=> ctl.load_glyph)
      else $error("accepted word not followed by glyph fetch");

   // the final pixel of a glyph hands over to the cursor update
   a_final_to_advance: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && status.final_fire) |=> ctl.advance)
      else $error("final pixel not followed by cursor advance");

endmodule

>>> src/bgsr_datapath.sv
// Datapath: cursor, glyph register, column/row walk, pixel output register.
// Depends on bgsr_pkg (font ROM, config, control and status structs).
module bgsr_datapath
   import bgsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  ctl_type                 ctl,
   output status_type              status,
   input  logic                    req_tvalid,
   input  logic [7:0]              req_char_code,
   input  logic                    req_start_flag,
   input  logic [ADDRESS_BITS-1:0] req_start_offset,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [ADDRESS_BITS-1:0] rsp_pixel_address,
   output logic [7:0]              rsp_pixel_value,
   output logic                    rsp_last_pixel
);

   logic [ADDRESS_BITS-1:0] cursor_ff, cursor_in;
   logic [7:0]              code_ff, code_in;
   logic [GLYPH_BITS-1:0]   glyph_ff, glyph_in;
   logic [1:0]              first_ff, first_in;
   logic [COL_W-1:0]        ncols_ff, ncols_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [ADDRESS_BITS-1:0] col_addr_ff, col_addr_in;
   logic [ADDRESS_BITS-1:0] pix_addr_ff, pix_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDRESS_BITS-1:0] out_addr_ff, out_addr_in;
   logic [7:0]              out_value_ff, out_value_in;
   logic                    out_last_ff, out_last_in;

   logic                    accept, in_range, fire, last_row, last_col;
   logic [1:0]              shift;
   logic [ADDRESS_BITS-1:0] col_step, row_step, adv;
   logic [2:0]              trim;
   logic [GIDX_W-1:0]       gidx;
   logic [7:0]              col_bits;

   assign accept   = req_tvalid && ctl.req_ready;
   assign in_range = (code_ff >= 8'(FIRST_CODE)) && (code_ff < 8'(FIRST_CODE + GLYPH_COUNT));
   assign gidx     = GIDX_W'(code_ff - 8'(FIRST_CODE));
   assign glyph_in = in_range ? FONT_ROM[gidx] : '0;
   assign trim     = 3'(glyph_in[1:0]) + 3'(glyph_in[3:2]);

   // scale 1, 2 or 4 as a shift; any other mode saturates to 4
   assign shift    = (cfg.scale_mode == SCALE_X1) ? 2'd0 :
                     (cfg.scale_mode == SCALE_X2) ? 2'd1 : 2'd2;
   assign col_step = ADDRESS_BITS'(3'd1 << shift);
   assign row_step = ADDRESS_BITS'(10'(cfg.row_stride) << shift);
   assign adv      = ADDRESS_BITS'(5'(ncols_ff) << shift) + ADDRESS_BITS'(cfg.gap_columns);

   assign col_bits = glyph_column(glyph_ff, COL_W'(col_ff + COL_W'(first_ff)));
   assign last_row = (row_ff == ROW_W'(GLYPH_ROWS - 1));
   assign last_col = (COL_W'(col_ff + 1'b1) == ncols_ff);
   assign fire     = ctl.emit && (!rsp_valid_ff || rsp_tready);

   assign status.drop       = (cursor_ff >= cfg.cursor_limit) || !in_range;
   assign status.no_cols    = (ncols_ff == '0);
   assign status.final_fire = fire && last_row && last_col;

   always_comb begin
      cursor_in    = cursor_ff;
      code_in      = code_ff;
      first_in     = first_ff;
      ncols_in     = ncols_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_addr_in  = col_addr_ff;
      pix_addr_in  = pix_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_addr_in  = out_addr_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;

      if (accept) begin
         code_in = req_char_code;
         if (req_start_flag) begin
            cursor_in = req_start_offset;
         end
      end

      if (ctl.load_glyph) begin
         if (cfg.full_width) begin
            first_in = 2'd0;
            ncols_in = COL_W'(GLYPH_COLUMNS);
         end else begin
            first_in = glyph_in[1:0];
            ncols_in = (trim < 3'(GLYPH_COLUMNS)) ? COL_W'(3'(GLYPH_COLUMNS) - trim) : '0;
         end
         col_in      = '0;
         row_in      = '0;
         col_addr_in = cursor_ff;
         pix_addr_in = cursor_ff;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
         out_addr_in  = pix_addr_ff;
         out_value_in = col_bits[row_ff] ? cfg.fg_color : cfg.bg_color;
         out_last_in  = last_row && last_col;
         if (last_row) begin
            row_in      = '0;
            col_in      = COL_W'(col_ff + 1'b1);
            col_addr_in = col_addr_ff + col_step;
            pix_addr_in = col_addr_ff + col_step;
         end else begin
            row_in      = ROW_W'(row_ff + 1'b1);
            pix_addr_in = pix_addr_ff + row_step;
         end
      end

      if (ctl.advance) begin
         cursor_in = cursor_ff + adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      first_ff     <= first_in;
      ncols_ff     <= ncols_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      col_addr_ff  <= col_addr_in;
      pix_addr_ff  <= pix_addr_in;
      out_addr_ff  <= out_addr_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      if (ctl.load_glyph) begin
         glyph_ff <= glyph_in;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_value   = out_value_ff;
   assign rsp_last_pixel    = out_last_ff;

   // the column walk never runs past the drawn width
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (col_ff < ncols_ff))
      else $error("column counter beyond drawn width");

   // a kept glyph starts its walk at the top of its first column
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (ctl.load_glyph && !status.drop) |=> (row_ff == '0 && col_ff == '0
                                            && pix_addr_ff == cursor_ff))
      else $error("glyph walk does not start at the cursor");

endmodule
